[src/aac_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aac_pkg: shared types and constants of the ARP address cache
// Field widths, operation codes and the structs that run along the cell chain.
// ----------------------------------------------------------------------------
package aac_pkg;

    localparam int OP_W  = 2;
    localparam int IP_W  = 32;
    localparam int MAC_W = 48;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    // Table entry as it moves from one cell to the next on an insert.
    typedef struct packed {
        logic             valid;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } t_entry;

    // Lookup token travelling down the chain, collecting the first match.
    typedef struct packed {
        logic             valid;
        logic [IP_W-1:0]  ip;
        logic             hit;
        logic [MAC_W-1:0] mac;
    } t_query;

    // Control broadcast to every cell.
    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctl;

endpackage

[src/aac_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aac_req_if: request channel of the ARP address cache
// Valid/ready channel carrying one operation per beat.
// ----------------------------------------------------------------------------
interface aac_req_if;
    import aac_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  opcode;
    logic [IP_W-1:0]  ip_address;
    logic [MAC_W-1:0] mac_address;

    modport source (output valid, output opcode, output ip_address, output mac_address,
                    input ready);
    modport sink   (input valid, input opcode, input ip_address, input mac_address,
                    output ready);
endinterface

[src/aac_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aac_rsp_if: response channel of the ARP address cache
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface aac_rsp_if;
    import aac_pkg::*;

    logic             valid;
    logic             ready;
    logic             hit;
    logic [MAC_W-1:0] found_mac;

    modport source (output valid, output hit, output found_mac, input ready);
    modport sink   (input valid, input hit, input found_mac, output ready);
endinterface

[src/aac_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aac_cell: one entry of the cache chain
// Holds one entry, takes its neighbour's entry on an insert and checks the
// passing lookup token against its own entry.
// ----------------------------------------------------------------------------
module aac_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  aac_pkg::t_cell_ctl i_ctl,
    input  aac_pkg::t_entry    i_entry,
    output aac_pkg::t_entry    o_entry,
    input  aac_pkg::t_query    i_query,
    output aac_pkg::t_query    o_query
);
    import aac_pkg::*;

    logic             r_valid;
    logic [IP_W-1:0]  r_ip;
    logic [MAC_W-1:0] r_mac;

    logic             r_q_valid;
    logic [IP_W-1:0]  r_q_ip;
    logic             r_q_hit;
    logic [MAC_W-1:0] r_q_mac;

    logic             match;
    logic             n_q_hit;
    logic [MAC_W-1:0] n_q_mac;

    // A token that already hit a newer entry keeps that entry's MAC.
    assign match   = r_valid && (r_ip == i_query.ip);
    assign n_q_hit = i_query.hit | match;
    assign n_q_mac = i_query.hit ? i_query.mac : (match ? r_mac : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_q_valid <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_valid <= 1'b0;
            end else if (i_ctl.shift) begin
                r_valid <= i_entry.valid;
            end
            r_q_valid <= i_query.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_ip  <= i_entry.ip;
            r_mac <= i_entry.mac;
        end
        r_q_ip  <= i_query.ip;
        r_q_hit <= n_q_hit;
        r_q_mac <= n_q_mac;
    end

    assign o_entry = '{valid: r_valid, ip: r_ip, mac: r_mac};
    assign o_query = '{valid: r_q_valid, ip: r_q_ip, hit: r_q_hit, mac: r_q_mac};

endmodule

[src/arp_address_cache_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_address_cache_top: IPv4 to MAC address cache
// A chain of ENTRIES cells holding the newest entry in front.
// ----------------------------------------------------------------------------
// Requests arrive on i_req, one operation per beat: clear, insert or lookup.
// Every request yields exactly one beat on o_rsp, in request order.
// An insert shifts every entry one cell down the chain and writes the new one
// into the first cell; the entry in the last cell drops out when the table is
// full. A lookup token walks the chain one cell per cycle, newest first, and
// keeps the MAC of the first valid match.
// Clear, insert and unused codes are answered from the result register in the
// cycle after acceptance and a new request may follow in the next cycle.
// A lookup token passes every cell of the chain before it reaches the result
// register, and no new request is accepted until then; the chain length sets this.
// One request is in work at a time. The result register frees the request
// side from the response side: i_req.ready needs the result register empty or
// being taken in the same cycle, so a stalled receiver holds off new requests.
// Reset empties the table and the result register; it is ready at once.
// ----------------------------------------------------------------------------
module arp_address_cache_top #(
    parameter int ENTRIES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    aac_req_if.sink   i_req,
    aac_rsp_if.source o_rsp
);
    import aac_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

    t_state           r_state;
    logic             r_out_valid;
    logic             r_out_hit;
    logic [MAC_W-1:0] r_out_mac;

    logic      accept;
    t_cell_ctl ctl;
    t_entry    new_entry;
    t_entry    entry_link [ENTRIES];
    t_query    query_link [ENTRIES+1];

    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        ctl = '{clear: 1'b0, shift: 1'b0};
        query_link[0] = '{valid: 1'b0, ip: i_req.ip_address, hit: 1'b0, mac: '0};
        if (accept) begin
            case (i_req.opcode)
                OP_CLEAR:  ctl.clear = 1'b1;
                OP_INSERT: ctl.shift = 1'b1;
                OP_LOOKUP: query_link[0].valid = 1'b1;
                default:   ;
            endcase
        end
    end

    assign new_entry = '{valid: 1'b1, ip: i_req.ip_address, mac: i_req.mac_address};

    // The entry leaving the last cell is the one that drops out of the table.
    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        aac_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_entry ((k == 0) ? new_entry : entry_link[(k == 0) ? 0 : k-1]),
            .o_entry (entry_link[k]),
            .i_query (query_link[k]),
            .o_query (query_link[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_req.opcode == OP_LOOKUP) begin
                            r_state <= S_SEARCH;
                            if (o_rsp.ready) begin
                                r_out_valid <= 1'b0;
                            end
                        end else begin
                            r_out_valid <= 1'b1;
                        end
                    end else if (o_rsp.ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_SEARCH: begin
                    if (query_link[ENTRIES].valid) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                    end else if (o_rsp.ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_req.opcode != OP_LOOKUP)) begin
            r_out_hit <= 1'b0;
            r_out_mac <= '0;
        end else if (query_link[ENTRIES].valid) begin
            r_out_hit <= query_link[ENTRIES].hit;
            r_out_mac <= query_link[ENTRIES].mac;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.hit       = r_out_hit;
    assign o_rsp.found_mac = r_out_mac;

endmodule
